@@ rtl/bb3_pkg.sv @@
// bb3_pkg: shared constants, types and helpers for the 3x3 RGB box blur.
// No dependencies; imported by box_blur_3x3_rgb.
`default_nettype none

package bb3_pkg;

  // Default line length bound (line store depth)
  localparam int unsigned MAX_WIDTH_DEF    = 1024;

  // Register reset values and widths
  localparam int unsigned FRAME_WIDTH_RST  = 640;
  localparam int unsigned FRAME_HEIGHT_RST = 480;
  localparam int unsigned FWIDTH_W         = 11;
  localparam int unsigned FHEIGHT_W        = 12;
  localparam int unsigned CFG_DATA_W       = 12;
  localparam int unsigned CFG_INDEX_W      = 1;

  // Nine 8-bit samples sum to at most 2295
  localparam int unsigned SUM_W            = 12;

  // ceil(2^16 / 9): exact floor(sum / 9) for every sum below 2296
  localparam int unsigned RECIP_W          = 13;
  localparam logic [RECIP_W-1:0] RECIP_9   = 13'd7282;
  localparam int unsigned DIV_SHIFT        = 16;
  localparam int unsigned PROD_W           = SUM_W + RECIP_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // floor(sum / 9) by reciprocal multiply
  function automatic logic [7:0] div9(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(RECIP_9);
    return prod[DIV_SHIFT+7:DIV_SHIFT];
  endfunction

endpackage

`default_nettype wire

@@ rtl/box_blur_3x3_rgb.sv @@
// box_blur_3x3_rgb: streaming 3x3 mean filter over RGB frames, line stores in RAM.
// Depends on bb3_pkg.
//
//   channel | dir | handshake                 | word contents
//   --------+-----+---------------------------+-------------------------------------
//   cfg     | in  | cfg_we_i                  | cfg_index_i, cfg_data_i
//   in      | in  | in_valid_i / in_ready_o   | kind_i, pixel_red/green/blue_i
//   out     | out | out_valid_o / out_ready_i | out_red/green/blue_o, last_of_frame_o
//
// Cycles: one input word per clock while in_ready_o is high. A word that produces a
// result moves through s1 (RAM read), s2 (window/sum) and the output register (divide).
// The rate is set by the single read/write port pair of each line store RAM.
// Stalls: in_ready_o drops only when the output register holds an untaken word
// and both internal stages hold results too.
// Reset: counters, window and pipeline valids clear at once; the line store RAMs
// are not cleared (no clearing pass).
`default_nettype none

module box_blur_3x3_rgb
  import bb3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input words
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   kind_i,
  input  wire logic [7:0]             pixel_red_i,
  input  wire logic [7:0]             pixel_green_i,
  input  wire logic [7:0]             pixel_blue_i,
  // output words
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [7:0]                  out_red_o,
  output logic [7:0]                  out_green_o,
  output logic [7:0]                  out_blue_o,
  output logic                        last_of_frame_o
);

  // column index, effective width, drain count widths
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW = $clog2(MAX_WIDTH + 2);
  localparam int unsigned WIDTH_RST =
    (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;

  // ---------------------------------------------------------------------------
  // Frame geometry (stored already clamped) and position counters
  // ---------------------------------------------------------------------------
  logic [WW-1:0]        frame_width_q;
  logic [FHEIGHT_W-1:0] frame_height_q;
  logic [WW-1:0]        width_wr;
  logic [FHEIGHT_W-1:0] height_wr;

  logic [FHEIGHT_W-1:0] in_row_q, in_row_d;
  logic [CW-1:0]        in_col_q, in_col_d;
  logic [FHEIGHT_W-1:0] out_row_q, out_row_d;
  logic [CW-1:0]        out_col_q, out_col_d;
  logic [PW-1:0]        pending_q, pending_d;

  logic [WW-1:0]        w_dec;
  logic [CW-1:0]        w_m1;
  logic [FHEIGHT_W-1:0] h_m1;

  // ---------------------------------------------------------------------------
  // Pipeline: s1 = RAM data back, s2 = sums ready, output register
  // ---------------------------------------------------------------------------
  logic          s1_valid_q, s1_pix_q, s1_emit_q, s1_border_q, s1_last_q, s1_lower_q;
  logic [CW-1:0] s1_addr_q;
  rgb_t          s1_px_q;

  logic             s2_valid_q, s2_border_q, s2_last_q;
  rgb_t             s2_center_q;
  logic [SUM_W-1:0] s2_sum_r_q, s2_sum_g_q, s2_sum_b_q;

  logic out_valid_q, out_last_q;
  rgb_t out_px_q;

  logic out_free, s2_go, s2_free, s1_go;
  logic accept, take_pix, take_drn, rd_en, mem_wr;
  logic emit, out_border, pending_zero;
  logic [CW-1:0] rd_addr;

  // line stores: lower = previous row, upper = row before that
  rgb_t mem_lo [MAX_WIDTH];
  rgb_t mem_up [MAX_WIDTH];
  rgb_t rd_lo_q, rd_up_q;

  // forwarding of a write that lands on the same edge as a read of that entry
  logic fwd_q;
  rgb_t fwd_lo_q, fwd_up_q;
  rgb_t mid_eff, top_eff;

  rgb_t             win_q   [9];
  rgb_t             win_new [9];
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  rgb_t             s1_center;
  rgb_t             in_px;

  // ---------------------------------------------------------------------------
  // Handshake chain
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_go      = s2_valid_q && out_free;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_go      = s1_valid_q && (!s1_emit_q || s2_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  assign accept       = in_valid_i && in_ready_o;
  assign pending_zero = (pending_q == '0);
  assign take_pix     = accept && !kind_i && pending_zero;   // pixels while draining drop
  assign take_drn     = accept && kind_i && !pending_zero;   // stray drains drop
  assign rd_en        = take_pix || take_drn;
  assign rd_addr      = kind_i ? out_col_q : in_col_q;
  assign mem_wr       = s1_go && s1_pix_q;

  assign in_px = '{red: pixel_red_i, green: pixel_green_i, blue: pixel_blue_i};

  // ---------------------------------------------------------------------------
  // Geometry decode and counter update at acceptance
  // ---------------------------------------------------------------------------
  always_comb begin
    w_dec = frame_width_q - WW'(1);
    w_m1  = w_dec[CW-1:0];
    h_m1  = frame_height_q - FHEIGHT_W'(1);

    if (cfg_data_i[FWIDTH_W-1:0] == '0) begin
      width_wr = WW'(1);
    end else if (32'(cfg_data_i[FWIDTH_W-1:0]) > MAX_WIDTH) begin
      width_wr = WW'(MAX_WIDTH);
    end else begin
      width_wr = WW'(cfg_data_i[FWIDTH_W-1:0]);
    end
    height_wr = (cfg_data_i == '0) ? FHEIGHT_W'(1) : cfg_data_i;

    // result for pixel index p - W - 1 becomes available with pixel p
    emit       = (in_row_q >= FHEIGHT_W'(2)) ||
                 ((in_row_q == FHEIGHT_W'(1)) && (in_col_q != '0));
    out_border = (out_row_q == '0) || (out_row_q == h_m1) ||
                 (out_col_q == '0) || (out_col_q == w_m1);

    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    pending_d = pending_q;

    if (take_pix) begin
      if (in_col_q == w_m1) begin
        in_col_d = '0;
        if (in_row_q == h_m1) begin
          in_row_d  = '0;
          // results still owed after the last pixel
          pending_d = (frame_height_q == FHEIGHT_W'(1)) ? PW'(frame_width_q)
                                                        : PW'(frame_width_q) + PW'(1);
        end else begin
          in_row_d = in_row_q + FHEIGHT_W'(1);
        end
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (emit) begin
        if (out_col_q == w_m1) begin
          out_col_d = '0;
          out_row_d = out_row_q + FHEIGHT_W'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end else if (take_drn) begin
      pending_d = pending_q - PW'(1);
      if (pending_q == PW'(1)) begin
        // frame done: restart positions
        in_row_d  = '0;
        in_col_d  = '0;
        out_row_d = '0;
        out_col_d = '0;
      end else if (out_col_q == w_m1) begin
        out_col_d = '0;
        out_row_d = out_row_q + FHEIGHT_W'(1);
      end else begin
        out_col_d = out_col_q + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Window shift and channel sums (s1)
  // ---------------------------------------------------------------------------
  assign mid_eff = fwd_q ? fwd_lo_q : rd_lo_q;
  assign top_eff = fwd_q ? fwd_up_q : rd_up_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_new[r*3]     = win_q[r*3 + 1];
      win_new[r*3 + 1] = win_q[r*3 + 2];
    end
    win_new[2] = top_eff;
    win_new[5] = mid_eff;
    win_new[8] = s1_px_q;

    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int i = 0; i < 9; i++) begin
      sum_r = sum_r + SUM_W'(win_new[i].red);
      sum_g = sum_g + SUM_W'(win_new[i].green);
      sum_b = sum_b + SUM_W'(win_new[i].blue);
    end

    // drains read a border pixel straight from the line store
    if (s1_pix_q) begin
      s1_center = win_new[4];
    end else begin
      s1_center = s1_lower_q ? mid_eff : top_eff;
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WW'(WIDTH_RST);
      frame_height_q <= FHEIGHT_W'(FRAME_HEIGHT_RST);
      in_row_q       <= '0;
      in_col_q       <= '0;
      out_row_q      <= '0;
      out_col_q      <= '0;
      pending_q      <= '0;
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      fwd_q          <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_FRAME_WIDTH:  frame_width_q  <= width_wr;
          REG_FRAME_HEIGHT: frame_height_q <= height_wr;
          default:          frame_width_q  <= frame_width_q;
        endcase
        in_row_q  <= '0;
        in_col_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
        pending_q <= '0;
      end else begin
        in_row_q  <= in_row_d;
        in_col_q  <= in_col_d;
        out_row_q <= out_row_d;
        out_col_q <= out_col_d;
        pending_q <= pending_d;
      end

      if (rd_en) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= mem_wr && (s1_addr_q == rd_addr);
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end

      if (mem_wr) begin
        for (int i = 0; i < 9; i++) begin
          win_q[i] <= win_new[i];
        end
      end

      if (s1_go && s1_emit_q) begin
        s2_valid_q <= 1'b1;
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end

      if (s2_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_pix_q    <= take_pix;
      s1_emit_q   <= take_drn || emit;
      s1_border_q <= take_drn || out_border;
      s1_last_q   <= take_drn && (pending_q == PW'(1));
      s1_lower_q  <= (out_row_q == h_m1);
      s1_addr_q   <= rd_addr;
      s1_px_q     <= in_px;
      fwd_lo_q    <= s1_px_q;
      fwd_up_q    <= mid_eff;
    end

    if (s1_go && s1_emit_q) begin
      s2_border_q <= s1_border_q;
      s2_last_q   <= s1_last_q;
      s2_center_q <= s1_center;
      s2_sum_r_q  <= sum_r;
      s2_sum_g_q  <= sum_g;
      s2_sum_b_q  <= sum_b;
    end

    if (s2_go) begin
      out_last_q <= s2_last_q;
      if (s2_border_q) begin
        out_px_q <= s2_center_q;
      end else begin
        out_px_q <= '{red:   div9(s2_sum_r_q),
                      green: div9(s2_sum_g_q),
                      blue:  div9(s2_sum_b_q)};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store RAMs: read at acceptance, write back when a pixel word leaves s1
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_lo_q <= mem_lo[rd_addr];
      rd_up_q <= mem_up[rd_addr];
    end
    if (mem_wr) begin
      mem_lo[s1_addr_q] <= s1_px_q;
      mem_up[s1_addr_q] <= mid_eff;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_red_o       = out_px_q.red;
  assign out_green_o     = out_px_q.green;
  assign out_blue_o      = out_px_q.blue;
  assign last_of_frame_o = out_last_q;

endmodule

`default_nettype wire

@@ rtl/bb3_checker.sv @@
// bb3_checker: port-level assertions for box_blur_3x3_rgb, plus its bind.
// Depends only on the top level's ports.
`default_nettype none

module bb3_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_red_o,
  input wire logic [7:0] out_green_o,
  input wire logic [7:0] out_blue_o,
  input wire logic       last_of_frame_o
);

  // input back-pressure only when every stage is full and the output is stalled
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("in_ready_o low without a stalled output word");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_red_o) && $stable(out_green_o) &&
       $stable(out_blue_o) && $stable(last_of_frame_o)))
    else $error("output word changed while stalled");

  // nothing is presented while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("out_valid_o high during reset");

  // after a reset release the pipeline is empty, so no word can appear at once
  a_no_word_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output word right after reset");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .out_red_o       (out_red_o),
  .out_green_o     (out_green_o),
  .out_blue_o      (out_blue_o),
  .last_of_frame_o (last_of_frame_o)
);

`default_nettype wire
